// ----- rtl/qts_pkg.sv -----
// Package for the two-stack queue: field widths, command and status codes,
// configuration defaults. No dependencies.
package qts_pkg;

	localparam int DATA_W        = 32;
	localparam int CMD_W         = 2;
	localparam int STATUS_W      = 2;
	localparam int CAP_W         = 5;
	localparam int DEPTH_DEFAULT = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FRONT = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;
	localparam logic signed [DATA_W-1:0] ZERO_WORD  = 32'sd0;

endpackage

// ----- rtl/qts_if.sv -----
// Channel interfaces of the two-stack queue: command items, result items and
// capacity writes. Depends on qts_pkg.
interface qts_req_if;
	import qts_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] data_in;
	modport source (output valid, command, data_in, input ready);
	modport sink   (input valid, command, data_in, output ready);
endinterface

interface qts_rsp_if;
	import qts_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data_out;
	logic [STATUS_W-1:0]      status;
	logic                     now_empty;
	modport source (output valid, data_out, status, now_empty, input ready);
	modport sink   (input valid, data_out, status, now_empty, output ready);
endinterface

interface qts_cfg_if;
	import qts_pkg::*;
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;
	modport source (output valid, capacity, input ready);
	modport sink   (input valid, capacity, output ready);
endinterface

// ----- rtl/qts_stack.sv -----
// Word store of one stack: one write port and one registered read port.
// Depends on qts_pkg.
module qts_stack #(
	parameter int DEPTH = qts_pkg::DEPTH_DEFAULT,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic signed [qts_pkg::DATA_W-1:0] wdata,
	input  logic                             re,
	input  logic [AW-1:0]                    raddr,
	output logic signed [qts_pkg::DATA_W-1:0] rdata
);
	import qts_pkg::*;

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/qts_ctrl.sv -----
// Sequencer of the two-stack queue: counts, word transfer, result register.
// Depends on qts_pkg, qts_if and qts_stack.
module qts_ctrl #(
	parameter int DEPTH = qts_pkg::DEPTH_DEFAULT,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] lim,
	qts_req_if.sink       req,
	qts_rsp_if.source     rsp
);
	import qts_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_XRD  = 3'd1;
	localparam logic [2:0] ST_XWR  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_FRD  = 3'd4;
	localparam logic [2:0] ST_RES  = 3'd5;

	logic [2:0]               state_q;
	logic [CW-1:0]            in_cnt_q;
	logic [CW-1:0]            out_cnt_q;
	logic                     deq_q;
	logic signed [DATA_W-1:0] res_data_q;
	logic [STATUS_W-1:0]      res_status_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic                     out_empty_q;

	logic                     accept;
	logic                     in_room;
	logic                     out_room;
	logic [CW-1:0]            in_dec;
	logic [CW-1:0]            out_dec;
	logic                     in_we;
	logic                     out_we;
	logic                     in_re;
	logic                     out_re;
	logic signed [DATA_W-1:0] in_rdata;
	logic signed [DATA_W-1:0] out_rdata;
	logic                     res_free;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_room   = (in_cnt_q < lim);
	assign out_room  = (out_cnt_q < lim);
	assign in_dec    = in_cnt_q - 1'b1;
	assign out_dec   = out_cnt_q - 1'b1;
	assign in_we     = accept && (req.command == CMD_ENQ) && in_room;
	assign in_re     = (state_q == ST_XRD);
	assign out_we    = (state_q == ST_XWR) && out_room;
	assign out_re    = (state_q == ST_CHK) && (out_cnt_q != '0);
	assign res_free  = !out_valid_q || rsp.ready;

	qts_stack #(.DEPTH(DEPTH)) u_in_stack (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_cnt_q[AW-1:0]),
		.wdata (req.data_in),
		.re    (in_re),
		.raddr (in_dec[AW-1:0]),
		.rdata (in_rdata)
	);

	qts_stack #(.DEPTH(DEPTH)) u_out_stack (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_cnt_q[AW-1:0]),
		.wdata (in_rdata),
		.re    (out_re),
		.raddr (out_dec[AW-1:0]),
		.rdata (out_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_cnt_q    <= '0;
			out_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && (state_q != ST_RES)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						deq_q <= (req.command == CMD_DEQ);
						unique case (req.command)
							CMD_ENQ: begin
								res_data_q <= ZERO_WORD;
								if (in_room) begin
									in_cnt_q     <= in_cnt_q + 1'b1;
									res_status_q <= STATUS_OK;
								end else begin
									res_status_q <= STATUS_FULL;
								end
								state_q <= ST_RES;
							end
							CMD_DEQ, CMD_FRONT: begin
								if (out_cnt_q == '0 && in_cnt_q != '0) begin
									state_q <= ST_XRD;
								end else begin
									state_q <= ST_CHK;
								end
							end
							default: begin
								res_data_q   <= ZERO_WORD;
								res_status_q <= STATUS_OK;
								state_q      <= ST_RES;
							end
						endcase
					end
				end
				ST_XRD: begin
					in_cnt_q <= in_dec;
					state_q  <= ST_XWR;
				end
				ST_XWR: begin
					if (out_room) begin
						out_cnt_q <= out_cnt_q + 1'b1;
					end
					state_q <= (in_cnt_q != '0) ? ST_XRD : ST_CHK;
				end
				ST_CHK: begin
					if (out_cnt_q == '0) begin
						res_data_q   <= EMPTY_WORD;
						res_status_q <= STATUS_EMPTY;
						state_q      <= ST_RES;
					end else begin
						state_q <= ST_FRD;
					end
				end
				ST_FRD: begin
					res_data_q   <= out_rdata;
					res_status_q <= STATUS_OK;
					if (deq_q) begin
						out_cnt_q <= out_dec;
					end
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (res_free) begin
						out_valid_q  <= 1'b1;
						out_data_q   <= res_data_q;
						out_status_q <= res_status_q;
						out_empty_q  <= (in_cnt_q == '0) && (out_cnt_q == '0);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.data_out  = out_data_q;
	assign rsp.status    = out_status_q;
	assign rsp.now_empty = out_empty_q;

endmodule

// ----- rtl/queue_from_two_stacks_top.sv -----
// Two-stack queue of signed 32-bit words; capacity register and sequencer.
// A dequeue or front first moves all in-stack words over when the out-stack is empty.
// One item at a time; the next is taken once the result is in the output register.
// Reset clears both counts and sets capacity to 16; stored words are not cleared.
// Depends on qts_pkg, qts_if, qts_stack and qts_ctrl.
module queue_from_two_stacks_top #(
	parameter int DEPTH = qts_pkg::DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	qts_req_if.sink   req,
	qts_rsp_if.source rsp,
	qts_cfg_if.sink   cfg
);
	import qts_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0] capacity_q;
	logic [LW-1:0]    cap_ext;
	logic [LW-1:0]    depth_ext;
	logic [LW-1:0]    lim_ext;
	logic [CW-1:0]    lim;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			capacity_q <= cfg.capacity;
		end
	end

	assign cap_ext   = LW'(capacity_q);
	assign depth_ext = LW'(DEPTH);
	assign lim_ext   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
	assign lim       = lim_ext[CW-1:0];

	qts_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.lim    (lim),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ----- tb/queue_from_two_stacks_top_tb.sv -----
// Testbench for queue_from_two_stacks_top: a directed table of commands, then random traffic
// under several idle patterns, checked against table values or an in-bench two-stack queue.
// Depends on qts_pkg, the qts_if interfaces and the queue_from_two_stacks_top RTL.
module queue_from_two_stacks_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qts_pkg::*;

	localparam int DEPTH        = DEPTH_DEFAULT;
	localparam int HALF_PERIOD  = 4;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 48;
	localparam int PHASES       = 4;
	localparam int SEGMENTS     = 4;
	localparam int SEG_ITEMS    = 56;
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [STATUS_W-1:0]      status;
		logic                     now_empty;
	} qts_result_t;

	typedef struct {
		bit                       set_cap;
		logic [CAP_W-1:0]         cap;
		logic [CMD_W-1:0]         command;
		logic signed [DATA_W-1:0] word;
		bit                       typed;
		qts_result_t              want;
	} cmd_row_t;

	typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

	logic clk;
	logic arst_n;

	qts_req_if req_ch ();
	qts_rsp_if rsp_ch ();
	qts_cfg_if cfg_ch ();

	queue_from_two_stacks_top #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	logic signed [DATA_W-1:0] push_words [DEPTH];
	logic signed [DATA_W-1:0] pop_words [DEPTH];
	int unsigned              push_cnt;
	int unsigned              pop_cnt;
	logic [CAP_W-1:0]         cap_reg;

	qts_result_t pending_results [$];
	bit          typed_on;
	qts_result_t typed_want;
	idle_mode_t  idle_mode;
	int          errors;
	int          quiet_cycles;
	cmd_row_t    directed [$];

	always #HALF_PERIOD clk = ~clk;

	function automatic qts_result_t apply_queue_op(input logic [CMD_W-1:0] op,
			input logic signed [DATA_W-1:0] word);
		qts_result_t r;
		int unsigned lim;
		lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
		r.data = ZERO_WORD;
		r.status = STATUS_OK;
		if (op == CMD_ENQ) begin
			if (push_cnt < lim) begin
				push_words[push_cnt] = word;
				push_cnt++;
			end else begin
				r.status = STATUS_FULL;
			end
		end else if (op == CMD_DEQ || op == CMD_FRONT) begin
			if (pop_cnt == 0) begin
				while (push_cnt > 0) begin
					push_cnt--;
					if (pop_cnt < lim) begin
						pop_words[pop_cnt] = push_words[push_cnt];
						pop_cnt++;
					end
				end
			end
			if (pop_cnt == 0) begin
				r.data = EMPTY_WORD;
				r.status = STATUS_EMPTY;
			end else begin
				r.data = pop_words[pop_cnt - 1];
				if (op == CMD_DEQ)
					pop_cnt--;
			end
		end
		r.now_empty = (push_cnt == 0 && pop_cnt == 0);
		return r;
	endfunction

	function automatic cmd_row_t plain_row(input logic [CMD_W-1:0] op,
			input logic signed [DATA_W-1:0] word);
		cmd_row_t row;
		row.set_cap = 1'b0;
		row.cap = CAP_RESET;
		row.command = op;
		row.word = word;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic cmd_row_t known_row(input logic [CMD_W-1:0] op,
			input logic signed [DATA_W-1:0] word, input logic signed [DATA_W-1:0] data,
			input logic [STATUS_W-1:0] status, input logic now_empty);
		cmd_row_t row;
		row = plain_row(op, word);
		row.typed = 1'b1;
		row.want.data = data;
		row.want.status = status;
		row.want.now_empty = now_empty;
		return row;
	endfunction

	function automatic cmd_row_t with_cap(input logic [CAP_W-1:0] cap, input cmd_row_t row);
		cmd_row_t r;
		r = row;
		r.set_cap = 1'b1;
		r.cap = cap;
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (errors < 100)
			$display("mismatch at %0t: %s got %h want %h", $realtime, field, got, want);
		errors++;
	endtask

	task automatic send_item(input logic [CMD_W-1:0] op, input logic signed [DATA_W-1:0] word);
		int pct;
		pct = (idle_mode == IDLE_SRC) ? 84 : (idle_mode == IDLE_BOTH) ? 37 : 0;
		while ($urandom_range(0, 99) < pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= op;
		req_ch.data_in <= word;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.capacity <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		qts_result_t r;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				cap_reg = cfg_ch.capacity;
			if (req_ch.valid && req_ch.ready) begin
				r = apply_queue_op(req_ch.command, req_ch.data_in);
				pending_results.push_back(typed_on ? typed_want : r);
			end
		end
	end

	always @(posedge clk) begin
		qts_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected item data_out", rsp_ch.data_out, '0);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.data_out !== want.data)
					flag_mismatch("data_out", rsp_ch.data_out, want.data);
				if (rsp_ch.status !== want.status)
					flag_mismatch("status", DATA_W'(rsp_ch.status), DATA_W'(want.status));
				if (rsp_ch.now_empty !== want.now_empty)
					flag_mismatch("now_empty", DATA_W'(rsp_ch.now_empty),
						DATA_W'(want.now_empty));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("queue_from_two_stacks_top_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(negedge clk) begin
		if (idle_mode == IDLE_SNK)
			rsp_ch.ready <= ($urandom_range(0, 99) >= 84);
		else if (idle_mode == IDLE_BOTH)
			rsp_ch.ready <= ($urandom_range(0, 99) >= 37);
		else
			rsp_ch.ready <= 1'b1;
	end

	initial begin
		logic [CAP_W-1:0]         cap_plan [PHASES * SEGMENTS];
		logic [CMD_W-1:0]         op;
		logic signed [DATA_W-1:0] word;
		int                       n;
		int                       len;
		int                       r;
		bit                       fill;

		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_ENQ;
		req_ch.data_in = ZERO_WORD;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.capacity = CAP_RESET;
		idle_mode = IDLE_NONE;
		cap_reg = CAP_RESET;
		push_cnt = 0;
		pop_cnt = 0;
		errors = 0;
		quiet_cycles = 0;
		typed_on = 1'b0;
		typed_want = '0;
		cap_plan = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd8, 5'd17, 5'd2,
			5'd16, 5'd4, 5'd1, 5'd12, 5'd31, 5'd6, 5'd2, 5'd16};

		directed.push_back(known_row(CMD_DEQ, ZERO_WORD, EMPTY_WORD, STATUS_EMPTY, 1'b1));
		directed.push_back(known_row(CMD_FRONT, 32'sh1234_5678, EMPTY_WORD, STATUS_EMPTY, 1'b1));
		directed.push_back(known_row(CMD_NOP, -32'sd1, ZERO_WORD, STATUS_OK, 1'b1));
		directed.push_back(known_row(CMD_ENQ, 32'sh7FFF_FFFF, ZERO_WORD, STATUS_OK, 1'b0));
		directed.push_back(known_row(CMD_ENQ, 32'sh8000_0000, ZERO_WORD, STATUS_OK, 1'b0));
		directed.push_back(known_row(CMD_ENQ, -32'sd1, ZERO_WORD, STATUS_OK, 1'b0));
		directed.push_back(known_row(CMD_ENQ, ZERO_WORD, ZERO_WORD, STATUS_OK, 1'b0));
		directed.push_back(plain_row(CMD_FRONT, 32'sh0F0F_0F0F));
		directed.push_back(plain_row(CMD_ENQ, 32'sh5555_5555));
		directed.push_back(plain_row(CMD_DEQ, ZERO_WORD));
		directed.push_back(plain_row(CMD_DEQ, ZERO_WORD));
		directed.push_back(known_row(CMD_NOP, ZERO_WORD, ZERO_WORD, STATUS_OK, 1'b0));
		directed.push_back(plain_row(CMD_DEQ, ZERO_WORD));
		directed.push_back(plain_row(CMD_DEQ, ZERO_WORD));
		directed.push_back(plain_row(CMD_DEQ, ZERO_WORD));
		directed.push_back(known_row(CMD_DEQ, ZERO_WORD, EMPTY_WORD, STATUS_EMPTY, 1'b1));
		directed.push_back(with_cap(5'd0,
			known_row(CMD_ENQ, 32'shAAAA_AAAA, ZERO_WORD, STATUS_FULL, 1'b1)));
		directed.push_back(known_row(CMD_FRONT, ZERO_WORD, EMPTY_WORD, STATUS_EMPTY, 1'b1));
		directed.push_back(with_cap(5'd1, plain_row(CMD_ENQ, 32'sd5)));
		directed.push_back(plain_row(CMD_ENQ, 32'sd6));
		directed.push_back(plain_row(CMD_DEQ, ZERO_WORD));
		directed.push_back(with_cap(5'd31, plain_row(CMD_ENQ, 32'sh0000_0011)));
		directed.push_back(plain_row(CMD_ENQ, 32'sh0000_0022));
		directed.push_back(plain_row(CMD_ENQ, 32'sh0000_0033));
		directed.push_back(with_cap(5'd1, plain_row(CMD_FRONT, ZERO_WORD)));
		directed.push_back(plain_row(CMD_DEQ, ZERO_WORD));

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].set_cap)
				write_capacity(directed[i].cap);
			typed_on = directed[i].typed;
			typed_want = directed[i].want;
			send_item(directed[i].command, directed[i].word);
		end
		typed_on = 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			idle_mode = idle_mode_t'(p);
			for (int s = 0; s < SEGMENTS; s++) begin
				if (s % 2 == 1)
					write_capacity(5'($urandom_range(1, 16)));
				else
					write_capacity(cap_plan[p * SEGMENTS + s]);
				n = 0;
				fill = 1'b1;
				while (n < SEG_ITEMS) begin
					len = $urandom_range(1, 20);
					for (int k = 0; k < len && n < SEG_ITEMS; k++) begin
						r = $urandom_range(0, 99);
						if (r < 4)
							op = CMD_NOP;
						else if (r < 84)
							op = fill ? CMD_ENQ : CMD_DEQ;
						else if (r < 94)
							op = CMD_FRONT;
						else
							op = fill ? CMD_DEQ : CMD_ENQ;
						r = $urandom_range(0, 99);
						if (r < 3)
							word = 32'sh7FFF_FFFF;
						else if (r < 6)
							word = 32'sh8000_0000;
						else if (r < 8)
							word = -32'sd1;
						else if (r < 10)
							word = ZERO_WORD;
						else
							word = $urandom;
						send_item(op, word);
						n++;
					end
					fill = !fill;
					if ($urandom_range(0, 9) == 0)
						wait_drained();
				end
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("queue_from_two_stacks_top_tb: clean");
		else
			$display("queue_from_two_stacks_top_tb: errors");
		$finish;
	end

endmodule
